// ===== rtl/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdi_pkg
// shared types and constants of the sorted doc-id set intersector
// ----------------------------------------------------------------------------
package sdi_pkg;

	localparam int SET_DEPTH = 1024;
	localparam int ID_BITS   = 31;
	localparam int ADDR_W    = $clog2(SET_DEPTH);
	localparam int CNT_W     = $clog2(SET_DEPTH + 1);

	// result kinds
	localparam logic KIND_DOC = 1'b0;
	localparam logic KIND_END = 1'b1;

	// config register byte addresses
	localparam int  PADDR_W        = 3;
	localparam logic [PADDR_W-1:0] REG_SET_LIMIT = 3'd0;
	localparam logic [CNT_W-1:0]   SET_LIMIT_RST = CNT_W'(SET_DEPTH);

	typedef enum logic {
		OP_LOAD,
		OP_MERGE
	} op_t;

	// classified input item
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		op_t                op;
		logic               lend;
		logic               fin;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic               kind;
		logic [CNT_W-1:0]   count;
		logic               ovf;
		logic               last;
	} res_t;

endpackage

// ===== rtl/sorted_docid_set_intersector.sv =====
// merge engine: takes one beat at a time; a merge beat reads stored entries until one is
//   not below its id, and a match on the last beat of a query is pushed before the end result
// reset: queues, positions, set count and overflow clear, set_limit returns to
//   1024; the set store is not cleared (it is only read where it was written)
// ----------------------------------------------------------------------------
// sorted_docid_set_intersector
// merge intersection of ascending doc-id lists against a stored set
// ----------------------------------------------------------------------------
module sorted_docid_set_intersector (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sdi_pkg::ID_BITS-1:0]  doc_id,
	input  logic                         first_list,
	input  logic                         list_end,
	input  logic                         final_list,
	// output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sdi_pkg::ID_BITS-1:0]  result_id,
	output logic                         result_kind,
	output logic [sdi_pkg::CNT_W-1:0]    match_count,
	output logic                         overflowed,
	output logic                         last_of_run,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sdi_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import sdi_pkg::*;

	logic [CNT_W-1:0] set_limit_q;
	logic             cfg_wr;
	logic             reg_hit;

	item_t            item;
	logic             item_valid;
	logic             pop;
	res_t             res;
	logic             push;
	logic             space;
	res_t             head;

	// config: one register, word-aligned decode
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_SET_LIMIT[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {{(32-CNT_W){1'b0}}, set_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_limit_q <= SET_LIMIT_RST;
		end else if (cfg_wr) begin
			set_limit_q <= pwdata[CNT_W-1:0];
		end
	end

	// front: takes beats and tags them load or merge
	sdi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.doc_id     (doc_id),
		.first_list (first_list),
		.list_end   (list_end),
		.final_list (final_list),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop)
	);

	// back: set store, read/write positions, merge loop
	sdi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.set_limit  (set_limit_q),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.space      (space),
		.push       (push),
		.res        (res)
	);

	// result queue decouples the engine from output stalls
	sdi_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign result_id   = head.id;
	assign result_kind = head.kind;
	assign match_count = head.count;
	assign overflowed  = head.ovf;
	assign last_of_run = head.last;

endmodule

// ===== rtl/sdi_front.sv =====
// ----------------------------------------------------------------------------
// sdi_front
// accepts input beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module sdi_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sdi_pkg::ID_BITS-1:0] doc_id,
	input  logic                       first_list,
	input  logic                       list_end,
	input  logic                       final_list,
	output logic                       item_valid,
	output sdi_pkg::item_t             item,
	input  logic                       pop
);
	import sdi_pkg::*;

	localparam int QD = 2;

	item_t      slot_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;
	item_t      cls;

	assign in_ready   = (cnt_q != 2'(QD));
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign take       = pop && item_valid;

	// classify: first-list ids load the set, others merge against it
	always_comb begin
		cls.id   = doc_id;
		cls.op   = first_list ? OP_LOAD : OP_MERGE;
		cls.lend = list_end;
		cls.fin  = final_list;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/sdi_back.sv =====
// ----------------------------------------------------------------------------
// sdi_back
// set store and merge engine: loads, merges and compacts, builds results
// ----------------------------------------------------------------------------
module sdi_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [sdi_pkg::CNT_W-1:0] set_limit,
	input  logic                      item_valid,
	input  sdi_pkg::item_t            item,
	output logic                      pop,
	input  logic                      space,
	output logic                      push,
	output sdi_pkg::res_t             res
);
	import sdi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;

	logic [ID_BITS-1:0] mem [SET_DEPTH];
	logic [ID_BITS-1:0] rdata_q;

	logic [1:0]         state_q, state_d;
	logic [ID_BITS-1:0] id_q, id_d;
	logic               lend_q, lend_d;
	logic               fin_q, fin_d;
	logic               match_q, match_d;
	logic [CNT_W-1:0]   rp_q, rp_d;
	logic [CNT_W-1:0]   wp_q, wp_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               ovf_q, ovf_d;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [ID_BITS-1:0] mem_wd;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_ra;

	logic [CNT_W-1:0]   cap;
	logic [CNT_W-1:0]   rp_nxt;

	assign cap    = (set_limit < CNT_W'(SET_DEPTH)) ? set_limit : CNT_W'(SET_DEPTH);
	assign rp_nxt = rp_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		id_d    = id_q;
		lend_d  = lend_q;
		fin_d   = fin_q;
		match_d = match_q;
		rp_d    = rp_q;
		wp_d    = wp_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		pop     = 1'b0;
		push    = 1'b0;
		mem_we  = 1'b0;
		mem_wa  = wp_q[ADDR_W-1:0];
		mem_wd  = id_q;
		mem_re  = 1'b0;
		mem_ra  = rp_q[ADDR_W-1:0];
		res.id    = id_q;
		res.kind  = KIND_DOC;
		res.count = '0;
		res.ovf   = ovf_q;
		res.last  = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					pop     = 1'b1;
					id_d    = item.id;
					lend_d  = item.lend;
					fin_d   = item.fin;
					match_d = 1'b0;
					state_d = ST_POST;
					if (item.op == OP_LOAD) begin
						if (wp_q < cap) begin
							mem_we  = 1'b1;
							mem_wd  = item.id;
							wp_d    = wp_q + CNT_W'(1);
							match_d = item.fin;
						end else begin
							ovf_d = 1'b1;
						end
					end else if (rp_q < cnt_q) begin
						mem_re  = 1'b1;
						state_d = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				if (rdata_q < id_q) begin
					// stored entry below the id: skip it and fetch the next, if any
					rp_d = rp_nxt;
					if (rp_nxt < cnt_q) begin
						mem_re = 1'b1;
						mem_ra = rp_nxt[ADDR_W-1:0];
					end else begin
						state_d = ST_POST;
					end
				end else if (rdata_q == id_q) begin
					// hit: compact into the write position
					if (wp_q < CNT_W'(SET_DEPTH)) begin
						mem_we = 1'b1;
						wp_d   = wp_q + CNT_W'(1);
					end
					rp_d    = rp_nxt;
					match_d = fin_q;
					state_d = ST_POST;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (match_q) begin
					if (space) begin
						push     = 1'b1;
						res.last = !(lend_q && fin_q);
						match_d  = 1'b0;
						state_d  = lend_q ? ST_POST : ST_IDLE;
					end
				end else if (lend_q) begin
					if (!fin_q || space) begin
						if (fin_q) begin
							push      = 1'b1;
							res.id    = '0;
							res.kind  = KIND_END;
							res.count = wp_q;
							ovf_d     = 1'b0;
						end
						cnt_d   = wp_q;
						rp_d    = '0;
						wp_d    = '0;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// set store, no reset: only entries below the set count are read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_d;
		lend_q <= lend_d;
		fin_q  <= fin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			match_q <= 1'b0;
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			match_q <= match_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

// ===== rtl/sdi_out.sv =====
// ----------------------------------------------------------------------------
// sdi_out
// result queue between the merge engine and the output channel
// ----------------------------------------------------------------------------
module sdi_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sdi_pkg::res_t res,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output sdi_pkg::res_t head
);
	import sdi_pkg::*;

	localparam int QD = 2;

	res_t       slot_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign space     = (cnt_q != 2'(QD));
	assign out_valid = (cnt_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];
	assign wr        = push && space;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
